/* rtl/dfcc_pkg.sv */
// Shared constants, types and codes for the disc footprint collision check.
package dfcc_pkg;

    // Grid geometry.
    localparam int MapSide   = 256;
    localparam int PosW      = 8;
    localparam int CoordW    = $clog2(MapSide);
    localparam int DimW      = CoordW + 1;
    localparam int AddrW     = 2 * CoordW;
    localparam int GridDepth = MapSide * MapSide;

    // Radius arithmetic: Q4.4 radius, half-side up to 16 cells.
    localparam int RadW   = 8;
    localparam int FracW  = 4;
    localparam int HalfW  = RadW - FracW + 1;
    localparam int OffW   = HalfW + 1;
    localparam int SqW    = 2 * HalfW;
    localparam int SumW   = SqW + 1;
    localparam int RsqW   = 2 * RadW;
    localparam int ScaleW = 2 * FracW;
    localparam int NxW    = PosW + 2;

    localparam int CntW     = 11;
    localparam int CfgW     = 9;
    localparam int CfgAddrW = 2;

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] REG_RADIUS     = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_MAP_WIDTH  = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_MAP_HEIGHT = 2'd2;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_DRAIN,
        SCAN_DONE
    } scan_state_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [CntW-1:0] count;
    } scan_status_t;

endpackage

/* rtl/dfcc_ram.sv */
// Generic single-port RAM with registered read.
module dfcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dfcc_scan.sv */
// Footprint scan sequencer: walks the bounding square and counts obstacle cells in the disc.
module dfcc_scan (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic                             ack,
    input  logic [dfcc_pkg::PosW-1:0]        center_x,
    input  logic [dfcc_pkg::PosW-1:0]        center_y,
    input  logic [dfcc_pkg::RadW-1:0]        radius_q4,
    input  logic [dfcc_pkg::DimW-1:0]        map_width,
    input  logic [dfcc_pkg::DimW-1:0]        map_height,
    input  logic                             rd_data,
    output logic                             rd_en,
    output logic [dfcc_pkg::AddrW-1:0]       rd_addr,
    output dfcc_pkg::scan_status_t           status
);

    dfcc_pkg::scan_state_t state_reg, state_next;

    logic signed [dfcc_pkg::OffW-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [dfcc_pkg::HalfW-1:0]        half_reg, half_next;
    logic [dfcc_pkg::PosW-1:0]         cx_reg, cx_next, cy_reg, cy_next;
    logic [dfcc_pkg::CntW-1:0]         count_reg, count_next;
    logic                              pend_reg, pend_next;

    logic [dfcc_pkg::RadW:0]           half_sum;
    logic [dfcc_pkg::HalfW-1:0]        half_calc;
    logic signed [dfcc_pkg::OffW-1:0]  half_s;
    logic                              last_pos;
    logic [dfcc_pkg::HalfW-1:0]        ax, ay;
    logic [dfcc_pkg::SumW-1:0]         d2;
    logic [dfcc_pkg::RsqW-1:0]         rsq;
    logic                              in_disc;
    logic signed [dfcc_pkg::NxW-1:0]   nx, ny;
    logic [dfcc_pkg::DimW-1:0]         w_use, h_use;
    logic                              in_map;
    logic [dfcc_pkg::CntW-1:0]         count_add;

    // Half-side is ceil(radius / 16).
    assign half_sum  = {1'b0, radius_q4} + (dfcc_pkg::RadW+1)'(15);
    assign half_calc = half_sum[dfcc_pkg::RadW:dfcc_pkg::FracW];
    assign half_s    = $signed({1'b0, half_reg});
    assign last_pos  = (dx_reg == half_s) && (dy_reg == half_s);

    // Disc test: 256 * (dx^2 + dy^2) <= radius_q4^2.
    assign ax  = dx_reg[dfcc_pkg::OffW-1] ? dfcc_pkg::HalfW'(-dx_reg)
                                          : dfcc_pkg::HalfW'(dx_reg);
    assign ay  = dy_reg[dfcc_pkg::OffW-1] ? dfcc_pkg::HalfW'(-dy_reg)
                                          : dfcc_pkg::HalfW'(dy_reg);
    assign d2  = dfcc_pkg::SumW'(ax) * dfcc_pkg::SumW'(ax)
               + dfcc_pkg::SumW'(ay) * dfcc_pkg::SumW'(ay);
    assign rsq = radius_q4 * radius_q4;
    assign in_disc = {d2, dfcc_pkg::ScaleW'(0)}
                     <= (dfcc_pkg::SumW + dfcc_pkg::ScaleW)'(rsq);

    // Neighbor coordinates and map bounds.
    assign nx = $signed({2'b00, cx_reg})
              + $signed({{(dfcc_pkg::NxW-dfcc_pkg::OffW){dx_reg[dfcc_pkg::OffW-1]}}, dx_reg});
    assign ny = $signed({2'b00, cy_reg})
              + $signed({{(dfcc_pkg::NxW-dfcc_pkg::OffW){dy_reg[dfcc_pkg::OffW-1]}}, dy_reg});
    assign w_use = (map_width > dfcc_pkg::DimW'(dfcc_pkg::MapSide))
                   ? dfcc_pkg::DimW'(dfcc_pkg::MapSide) : map_width;
    assign h_use = (map_height > dfcc_pkg::DimW'(dfcc_pkg::MapSide))
                   ? dfcc_pkg::DimW'(dfcc_pkg::MapSide) : map_height;
    assign in_map = !nx[dfcc_pkg::NxW-1] && !ny[dfcc_pkg::NxW-1]
                    && (nx[dfcc_pkg::DimW-1:0] < w_use)
                    && (ny[dfcc_pkg::DimW-1:0] < h_use);

    assign rd_addr = {ny[dfcc_pkg::CoordW-1:0], nx[dfcc_pkg::CoordW-1:0]};

    // The read issued last cycle returns now; add it in if it was a kept cell.
    assign count_add = count_reg + dfcc_pkg::CntW'(pend_reg & rd_data);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dfcc_pkg::SCAN_IDLE:  if (start) state_next = dfcc_pkg::SCAN_RUN;
            dfcc_pkg::SCAN_RUN:   if (last_pos) state_next = dfcc_pkg::SCAN_DRAIN;
            dfcc_pkg::SCAN_DRAIN: state_next = dfcc_pkg::SCAN_DONE;
            dfcc_pkg::SCAN_DONE:  if (ack) state_next = dfcc_pkg::SCAN_IDLE;
            default:              state_next = dfcc_pkg::SCAN_IDLE;
        endcase
    end

    always_comb begin
        rd_en        = (state_reg == dfcc_pkg::SCAN_RUN);
        status.busy  = (state_reg != dfcc_pkg::SCAN_IDLE);
        status.done  = (state_reg == dfcc_pkg::SCAN_DONE);
        status.count = count_reg;
    end

    always_comb begin
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        half_next  = half_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        count_next = count_reg;
        pend_next  = 1'b0;
        unique case (state_reg)
            dfcc_pkg::SCAN_IDLE: begin
                if (start) begin
                    half_next  = half_calc;
                    dx_next    = -$signed({1'b0, half_calc});
                    dy_next    = -$signed({1'b0, half_calc});
                    cx_next    = center_x;
                    cy_next    = center_y;
                    count_next = '0;
                end
            end
            dfcc_pkg::SCAN_RUN: begin
                count_next = count_add;
                pend_next  = in_disc && in_map;
                if (dx_reg == half_s) begin
                    dx_next = -half_s;
                    dy_next = dy_reg + dfcc_pkg::OffW'(1);
                end else begin
                    dx_next = dx_reg + dfcc_pkg::OffW'(1);
                end
            end
            dfcc_pkg::SCAN_DRAIN: begin
                count_next = count_add;
            end
            dfcc_pkg::SCAN_DONE: begin
                count_next = count_reg;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dfcc_pkg::SCAN_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        half_reg  <= half_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        count_reg <= count_next;
    end

endmodule

/* rtl/disc_footprint_collision_check.sv */
// Top level of the disc footprint collision check: ports, configuration, grid RAM, result register.
//
//  Channel  | Ports                         | Contents
//  ---------+-------------------------------+---------------------------------------------
//  input    | s_tvalid s_tready s_tdata     | tdata: pos_x, pos_y, cell_blocked; tuser: req_type
//           | s_tuser                       |
//  result   | m_tvalid m_tready m_tdata     | tdata: passable, collision_count
//  config   | cfg_we cfg_addr cfg_wdata     | 0 radius_q4, 1 map_width, 2 map_height
//
// A cell write gives no result. A query walks the square of
// half-side h = ceil(radius_q4 / 16) one cell per cycle through the single RAM port;
// s_tready is low meanwhile. A finished scan holds its count until the output register
// is free, and the input stays stalled until then.
// Reset (aresetn, synchronous) clears control state and sets the configuration registers
// to radius 0 and a 256 by 256 map; the grid is undefined until written.
module disc_footprint_collision_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // pos_x[7:0], pos_y[15:8], cell_blocked[16]
    input  logic [0:0]                    s_tuser,   // req_type[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // passable[0], collision_count[11:1]
    input  logic                          cfg_we,
    input  logic [dfcc_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [dfcc_pkg::CfgW-1:0]     cfg_wdata
);

    logic [dfcc_pkg::RadW-1:0] radius_reg;
    logic [dfcc_pkg::DimW-1:0] width_reg, height_reg;

    logic [dfcc_pkg::PosW-1:0] pos_x, pos_y;
    logic                      cell_blocked, req_type;
    logic                      in_xfer, wr_en, start, load;

    dfcc_pkg::scan_status_t    status;
    logic                      rd_en, rd_data;
    logic [dfcc_pkg::AddrW-1:0] rd_addr, ram_addr;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic [15:0]               m_tdata_reg;

    assign pos_x        = s_tdata[7:0];
    assign pos_y        = s_tdata[15:8];
    assign cell_blocked = s_tdata[16];
    assign req_type     = s_tuser[0];

    assign s_tready = !status.busy;
    assign in_xfer  = s_tvalid && s_tready;
    assign wr_en    = in_xfer && (req_type == dfcc_pkg::REQ_WRITE);
    assign start    = in_xfer && (req_type == dfcc_pkg::REQ_QUERY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            width_reg  <= dfcc_pkg::DimW'(dfcc_pkg::MapSide);
            height_reg <= dfcc_pkg::DimW'(dfcc_pkg::MapSide);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                dfcc_pkg::REG_RADIUS:     radius_reg <= cfg_wdata[dfcc_pkg::RadW-1:0];
                dfcc_pkg::REG_MAP_WIDTH:  width_reg  <= cfg_wdata;
                dfcc_pkg::REG_MAP_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The RAM port serves cell writes when idle and scan reads while a scan runs.
    assign ram_addr = rd_en ? rd_addr : {pos_y, pos_x};

    dfcc_ram #(
        .WIDTH (1),
        .DEPTH (dfcc_pkg::GridDepth)
    ) u_grid (
        .aclk  (aclk),
        .we    (wr_en),
        .addr  (ram_addr),
        .wdata (cell_blocked),
        .rdata (rd_data)
    );

    dfcc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .ack        (load),
        .center_x   (pos_x),
        .center_y   (pos_y),
        .radius_q4  (radius_reg),
        .map_width  (width_reg),
        .map_height (height_reg),
        .rd_data    (rd_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .status     (status)
    );

    assign load = status.done && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (load) begin
            m_tdata_reg <= {4'b0000, status.count, (status.count == '0)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A query transfer starts a scan, so no further input is taken next cycle.
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == dfcc_pkg::REQ_QUERY) |=> !s_tready)
        else $error("input still ready after a query transfer");

    // The passable flag always agrees with the obstacle count.
    a_pass_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[11:1] == 11'd0)))
        else $error("passable flag disagrees with collision count");

    // The disc never holds more than 33 by 33 cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:1] <= 11'd1089))
        else $error("collision count exceeds the bounding square");

    // A result is loaded only when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending result");

endmodule
